// ===== sv/rlfw_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfw_pkg
// shared types and constants for the recursive lock with fifo wait queue
// ----------------------------------------------------------------------------
package rlfw_pkg;

   localparam int NUM_THREADS_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 8;

   localparam int TID_WIDTH    = 4;
   localparam int STATUS_WIDTH = 3;
   localparam int DEPTH_WIDTH  = 8;
   localparam int MAP_WIDTH    = 1 << TID_WIDTH;
   localparam int QUEUE_LIMIT  = 16;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_GRANTED      = 3'd0,
      STS_REGRANTED    = 3'd1,
      STS_BLOCKED      = 3'd2,
      STS_PARTIAL      = 3'd3,
      STS_FREED        = 3'd4,
      STS_ALREADY_WAIT = 3'd5,
      STS_NOT_HOLDER   = 3'd6,
      STS_OVERFLOW     = 3'd7
   } status_type;

   typedef enum logic {
      REQ_ACQUIRE = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       exec;
      status_type status;
   } ctrl_cmd_type;

   // datapath to controller, about the latched request and the lock state
   typedef struct packed {
      logic is_release;
      logic waiting;
      logic holder;
      logic taken;
      logic count_max;
      logic count_gt1;
      logic queue_full;
   } dp_flags_type;

endpackage

// ===== sv/rlfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlfw_ctrl
// request sequencer: latches a request, then picks the outcome from the flags
// ----------------------------------------------------------------------------
module rlfw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rlfw_pkg::dp_flags_type flags,
   output rlfw_pkg::ctrl_cmd_type cmd
);

   rlfw_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlfw_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.exec   = 1'b0;
      cmd.status = rlfw_pkg::STS_NOT_HOLDER;
      busy       = 1'b0;
      case (state_ff)
         rlfw_pkg::FSM_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rlfw_pkg::FSM_EXEC;
            end
         end
         rlfw_pkg::FSM_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
            state_in = rlfw_pkg::FSM_IDLE;
            if (!flags.is_release) begin
               if (flags.waiting) begin
                  cmd.status = rlfw_pkg::STS_ALREADY_WAIT;
               end else if (flags.holder) begin
                  cmd.status = flags.count_max ? rlfw_pkg::STS_OVERFLOW
                                               : rlfw_pkg::STS_REGRANTED;
               end else if (!flags.taken) begin
                  cmd.status = rlfw_pkg::STS_GRANTED;
               end else if (flags.queue_full) begin
                  cmd.status = rlfw_pkg::STS_ALREADY_WAIT;
               end else begin
                  cmd.status = rlfw_pkg::STS_BLOCKED;
               end
            end else begin
               if (!flags.holder) begin
                  cmd.status = rlfw_pkg::STS_NOT_HOLDER;
               end else if (flags.count_gt1) begin
                  cmd.status = rlfw_pkg::STS_PARTIAL;
               end else begin
                  cmd.status = rlfw_pkg::STS_FREED;
               end
            end
         end
         default: begin
            state_in = rlfw_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/rlfw_datapath.sv =====
// ----------------------------------------------------------------------------
// rlfw_datapath
// lock registers, wait queue ring and result registers
// ----------------------------------------------------------------------------
module rlfw_datapath #(
   parameter int NUM_THREADS = rlfw_pkg::NUM_THREADS_DEF,
   parameter int COUNT_WIDTH = rlfw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_type,
   input  logic [rlfw_pkg::TID_WIDTH-1:0]      req_thread_id,
   input  rlfw_pkg::ctrl_cmd_type              cmd,
   output rlfw_pkg::dp_flags_type              flags,
   output logic                                rsp_valid,
   output logic [rlfw_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic                                rsp_woken_valid,
   output logic [rlfw_pkg::TID_WIDTH-1:0]      rsp_woken_thread,
   output logic [rlfw_pkg::DEPTH_WIDTH-1:0]    rsp_hold_depth
);

   localparam int QDEPTH = (NUM_THREADS < rlfw_pkg::QUEUE_LIMIT) ? NUM_THREADS
                                                                   : rlfw_pkg::QUEUE_LIMIT;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int TW     = rlfw_pkg::TID_WIDTH;
   localparam int MW     = rlfw_pkg::MAP_WIDTH;

   // latched request
   logic                   req_rel_ff;
   logic [TW-1:0]          req_tid_ff;

   // lock state
   logic                   taken_ff, taken_in;
   logic [TW-1:0]          owner_ff, owner_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   // wait queue
   logic [TW-1:0]          queue_ff [QDEPTH];
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [QCNT_W-1:0]      qcnt_ff, qcnt_in;
   logic [MW-1:0]          map_ff, map_in;
   logic                   push;

   // result
   logic                   rsp_valid_ff;
   logic [rlfw_pkg::STATUS_WIDTH-1:0] status_ff;
   logic                   wv_ff, wv_in;
   logic [TW-1:0]          wt_ff, wt_in;
   logic [rlfw_pkg::DEPTH_WIDTH-1:0]  depth_ff, depth_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_rel_ff <= req_type;
         req_tid_ff <= req_thread_id;
      end
   end

   // flags for the controller
   always_comb begin
      flags.is_release = req_rel_ff;
      flags.waiting    = map_ff[req_tid_ff];
      flags.holder     = taken_ff && (owner_ff == req_tid_ff);
      flags.taken      = taken_ff;
      flags.count_max  = (cnt_ff == {COUNT_WIDTH{1'b1}});
      flags.count_gt1  = (cnt_ff > COUNT_WIDTH'(1));
      flags.queue_full = (qcnt_ff == QCNT_W'(QDEPTH));
   end

   // next state per chosen outcome
   always_comb begin
      taken_in = taken_ff;
      owner_in = owner_ff;
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      qcnt_in  = qcnt_ff;
      map_in   = map_ff;
      push     = 1'b0;
      wv_in    = 1'b0;
      wt_in    = '0;
      case (cmd.status)
         rlfw_pkg::STS_GRANTED: begin
            taken_in = 1'b1;
            owner_in = req_tid_ff;
            cnt_in   = COUNT_WIDTH'(1);
         end
         rlfw_pkg::STS_REGRANTED: begin
            cnt_in = cnt_ff + COUNT_WIDTH'(1);
         end
         rlfw_pkg::STS_BLOCKED: begin
            push    = 1'b1;
            tail_in = (tail_ff == PTR_W'(QDEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
            qcnt_in = qcnt_ff + QCNT_W'(1);
            map_in  = map_ff | (MW'(1) << req_tid_ff);
         end
         rlfw_pkg::STS_PARTIAL: begin
            cnt_in = cnt_ff - COUNT_WIDTH'(1);
         end
         rlfw_pkg::STS_FREED: begin
            taken_in = 1'b0;
            owner_in = '0;
            cnt_in   = '0;
            if (qcnt_ff != '0) begin
               wv_in   = 1'b1;
               wt_in   = queue_ff[head_ff];
               head_in = (head_ff == PTR_W'(QDEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
               qcnt_in = qcnt_ff - QCNT_W'(1);
               map_in  = map_ff & ~(MW'(1) << queue_ff[head_ff]);
            end
         end
         default: begin
         end
      endcase
   end

   // reported depth saturates at the width of the port
   generate
      if (COUNT_WIDTH > rlfw_pkg::DEPTH_WIDTH) begin : g_sat
         assign depth_in = (cnt_in > COUNT_WIDTH'(255)) ? '1
                                                        : cnt_in[rlfw_pkg::DEPTH_WIDTH-1:0];
      end else begin : g_ext
         assign depth_in = rlfw_pkg::DEPTH_WIDTH'(cnt_in);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff     <= 1'b0;
         owner_ff     <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         qcnt_ff      <= '0;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.exec) begin
            taken_ff <= taken_in;
            owner_ff <= owner_in;
            cnt_ff   <= cnt_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            qcnt_ff  <= qcnt_in;
            map_ff   <= map_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         queue_ff[tail_ff] <= req_tid_ff;
      end
      if (cmd.exec) begin
         status_ff <= cmd.status;
         wv_ff     <= wv_in;
         wt_ff     <= wt_in;
         depth_ff  <= depth_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_valid  = wv_ff;
   assign rsp_woken_thread = wt_ff;
   assign rsp_hold_depth   = depth_ff;

   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QCNT_W'(QDEPTH))
      else $error("wait queue count beyond capacity");

   a_map_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(map_ff) == int'(qcnt_ff))
      else $error("waiting map out of step with queue count");

   a_free_has_zero_count: assert property (@(posedge clock) disable iff (reset)
      !taken_ff |-> (cnt_ff == '0 && owner_ff == '0))
      else $error("free lock with nonzero count or owner");

   a_taken_has_count: assert property (@(posedge clock) disable iff (reset)
      taken_ff |-> cnt_ff != '0)
      else $error("held lock with zero count");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("executed request gave no result");

endmodule

// ===== sv/recursive_lock_fifo_waiters_unit.sv =====
// sequence: a request is latched at its transfer edge, then decided in the EXEC
//   state and registered into the result registers, which raise rsp_valid
// requests: the two-state sequencer takes no new request while it decides the last; busy is
//   high in the decide cycle; the receiver cannot stall, results are never held
// reset: synchronous, active high; lock free, queue empty, no result pending
// ----------------------------------------------------------------------------
// recursive_lock_fifo_waiters_unit
// recursive lock with owner, hold count and a fifo of waiting threads
// ----------------------------------------------------------------------------
module recursive_lock_fifo_waiters_unit #(
   parameter int NUM_THREADS = rlfw_pkg::NUM_THREADS_DEF,
   parameter int COUNT_WIDTH = rlfw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [rlfw_pkg::TID_WIDTH-1:0]     req_thread_id,
   // result channel
   output logic                               rsp_valid,
   output logic [rlfw_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                               rsp_woken_valid,
   output logic [rlfw_pkg::TID_WIDTH-1:0]     rsp_woken_thread,
   output logic [rlfw_pkg::DEPTH_WIDTH-1:0]   rsp_hold_depth
);

   // command and status between sequencer and datapath
   rlfw_pkg::ctrl_cmd_type cmd;
   rlfw_pkg::dp_flags_type flags;

   // sequencer: latches on a transfer, then picks the outcome from the flags
   rlfw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   // datapath: lock owner and count, wait queue ring, waiting map, result regs
   rlfw_datapath #(
      .NUM_THREADS (NUM_THREADS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_thread_id    (req_thread_id),
      .cmd              (cmd),
      .flags            (flags),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_hold_depth   (rsp_hold_depth)
   );

endmodule

// ===== bench/rlfw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlfw_checker
// watches both channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module rlfw_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_type,
   input  logic [rlfw_pkg::TID_WIDTH-1:0]     req_thread_id,
   input  logic                               rsp_valid,
   input  logic [rlfw_pkg::STATUS_WIDTH-1:0]  rsp_status,
   input  logic                               rsp_woken_valid,
   input  logic [rlfw_pkg::TID_WIDTH-1:0]     rsp_woken_thread,
   input  logic [rlfw_pkg::DEPTH_WIDTH-1:0]   rsp_hold_depth,
   output int                                 error_count,
   output int                                 pending,
   output int                                 checked,
   output logic [7:0]                         status_mask,
   output logic                               lock_held,
   output logic [rlfw_pkg::TID_WIDTH-1:0]     lock_owner,
   output logic [rlfw_pkg::MAP_WIDTH-1:0]     waiting_map
);
   import rlfw_pkg::*;

   localparam int DEPTH_MAX = (1 << COUNT_WIDTH_DEF) - 1;
   localparam int WAIT_CAP  = NUM_THREADS_DEF < QUEUE_LIMIT ? NUM_THREADS_DEF : QUEUE_LIMIT;

   typedef struct packed {
      status_type             status;
      logic                   woken_valid;
      logic [TID_WIDTH-1:0]   woken_thread;
      logic [DEPTH_WIDTH-1:0] hold_depth;
   } lock_outcome_type;

   // predicted lock state
   logic                    held;
   logic [TID_WIDTH-1:0]    owner;
   logic [COUNT_WIDTH_DEF-1:0] depth;
   logic [TID_WIDTH-1:0]    wait_line [QUEUE_LIMIT];
   logic [3:0]              line_head;
   logic [3:0]              line_tail;
   logic [4:0]              waiters;
   logic [MAP_WIDTH-1:0]    queued;

   lock_outcome_type outcome_q [$];

   task automatic lock_apply(input req_kind_type kind, input logic [TID_WIDTH-1:0] tid,
                             output lock_outcome_type res);
      logic is_holder;
      is_holder = held && owner == tid;
      res = '0;
      if (kind == REQ_ACQUIRE) begin
         if (queued[tid]) begin
            res.status = STS_ALREADY_WAIT;
         end else if (is_holder) begin
            if (depth >= DEPTH_MAX) begin
               res.status = STS_OVERFLOW;
            end else begin
               depth = depth + 1'b1;
               res.status = STS_REGRANTED;
            end
         end else if (!held) begin
            held  = 1'b1;
            owner = tid;
            depth = COUNT_WIDTH_DEF'(1);
            res.status = STS_GRANTED;
         end else if (waiters >= WAIT_CAP) begin
            res.status = STS_ALREADY_WAIT;
         end else begin
            wait_line[line_tail] = tid;
            line_tail   = line_tail + 1'b1;
            waiters     = waiters + 1'b1;
            queued[tid] = 1'b1;
            res.status  = STS_BLOCKED;
         end
      end else begin
         if (!is_holder) begin
            res.status = STS_NOT_HOLDER;
         end else if (depth > 1) begin
            depth = depth - 1'b1;
            res.status = STS_PARTIAL;
         end else begin
            held  = 1'b0;
            owner = '0;
            depth = '0;
            if (waiters > 0) begin
               res.woken_valid  = 1'b1;
               res.woken_thread = wait_line[line_head];
               line_head = line_head + 1'b1;
               waiters   = waiters - 1'b1;
               queued[res.woken_thread] = 1'b0;
            end
            res.status = STS_FREED;
         end
      end
      res.hold_depth = depth > 255 ? 8'd255 : depth;
   endtask

   always @(posedge clock) begin : monitor
      lock_outcome_type fresh;
      lock_outcome_type oldest;
      if (reset) begin
         held        = 1'b0;
         owner       = '0;
         depth       = '0;
         line_head   = '0;
         line_tail   = '0;
         waiters     = '0;
         queued      = '0;
         error_count = 0;
         checked     = 0;
         status_mask = '0;
         outcome_q.delete();
      end else begin
         if (start && !busy) begin
            lock_apply(req_kind_type'(req_type), req_thread_id, fresh);
            outcome_q.push_back(fresh);
         end
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               $error("result with nothing expected: status %0d", rsp_status);
               error_count++;
            end else begin
               oldest = outcome_q.pop_front();
               checked++;
               status_mask[rsp_status] = 1'b1;
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  error_count++;
               end
               if (rsp_woken_valid !== oldest.woken_valid) begin
                  $error("woken_valid: expected %0d, got %0d", oldest.woken_valid,
                         rsp_woken_valid);
                  error_count++;
               end
               if (rsp_woken_thread !== oldest.woken_thread) begin
                  $error("woken_thread: expected %0d, got %0d", oldest.woken_thread,
                         rsp_woken_thread);
                  error_count++;
               end
               if (rsp_hold_depth !== oldest.hold_depth) begin
                  $error("hold_depth: expected %0d, got %0d", oldest.hold_depth,
                         rsp_hold_depth);
                  error_count++;
               end
            end
         end
      end
      pending     <= outcome_q.size();
      lock_held   <= held;
      lock_owner  <= owner;
      waiting_map <= queued;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives lock requests into the recursive lock unit and reports the verdict;
// a directed opening walks through grant, regrant, blocking, wake-up and the
// not-holder and already-waiting codes, then random episodes mix contention,
// crowded queues, deep recursion up to saturation and plain noise
// ----------------------------------------------------------------------------
module tb;
   import rlfw_pkg::*;

   localparam int RANDOM_ITEMS   = 1250;
   localparam int QUIET_FROM     = 700;   // no sender gaps in this stretch
   localparam int QUIET_TO       = 950;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_type;
   logic [TID_WIDTH-1:0]    req_thread_id;
   logic                    rsp_valid;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic                    rsp_woken_valid;
   logic [TID_WIDTH-1:0]    rsp_woken_thread;
   logic [DEPTH_WIDTH-1:0]  rsp_hold_depth;

   // from the checker: verdict inputs and a view of the predicted lock
   int                      error_count;
   int                      pending;
   int                      checked;
   logic [7:0]              status_mask;
   logic                    lock_held;
   logic [TID_WIDTH-1:0]    lock_owner;
   logic [MAP_WIDTH-1:0]    waiting_map;

   int sent = 0;
   int stall_cycles = 0;

   recursive_lock_fifo_waiters_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_hold_depth   (rsp_hold_depth)
   );

   rlfw_checker lock_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_hold_depth   (rsp_hold_depth),
      .error_count      (error_count),
      .pending          (pending),
      .checked          (checked),
      .status_mask      (status_mask),
      .lock_held        (lock_held),
      .lock_owner       (lock_owner),
      .waiting_map      (waiting_map)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one request transfer; random sender gaps before it, then hold start
   // until the unit is not busy at a rising edge
   task automatic send_request(input req_kind_type kind, input logic [TID_WIDTH-1:0] tid);
      logic quiet;
      quiet = sent >= QUIET_FROM && sent < QUIET_TO;
      while (!quiet && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= kind;
      req_thread_id <= tid;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // release by the holder until the lock is free; the view of the lock lags
   // by one transfer, so the tail end gives a harmless not-holder release
   task automatic drain_lock();
      while (lock_held) send_request(REQ_RELEASE, lock_owner);
   endtask

   // stimulus
   initial begin : stimulus
      int                   roll;
      int                   reps;
      int                   pool_size;
      logic [TID_WIDTH-1:0] pool [5];
      logic [TID_WIDTH-1:0] tid;
      bit                   deep_done;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_type      <= REQ_ACQUIRE;
      req_thread_id <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_request(REQ_RELEASE, 4'd0);    // release of a free lock
      send_request(REQ_ACQUIRE, 4'd15);   // grant
      send_request(REQ_ACQUIRE, 4'd15);   // regrant, depth two
      send_request(REQ_RELEASE, 4'd0);    // release by a non-holder
      send_request(REQ_ACQUIRE, 4'd0);    // blocked, queued first
      send_request(REQ_ACQUIRE, 4'd0);    // already waiting
      send_request(REQ_ACQUIRE, 4'd5);    // blocked
      send_request(REQ_ACQUIRE, 4'd10);   // blocked
      send_request(REQ_RELEASE, 4'd15);   // partial release
      send_request(REQ_RELEASE, 4'd15);   // freed, wakes thread 0
      send_request(REQ_ACQUIRE, 4'd5);    // still queued on a free lock
      send_request(REQ_ACQUIRE, 4'd0);    // woken thread takes the lock
      send_request(REQ_RELEASE, 4'd0);    // freed, wakes thread 5
      send_request(REQ_RELEASE, 4'd0);    // release of a free lock again
      send_request(REQ_ACQUIRE, 4'd10);   // still queued
      send_request(REQ_ACQUIRE, 4'd5);    // grant
      send_request(REQ_RELEASE, 4'd5);    // freed, wakes thread 10
      send_request(REQ_ACQUIRE, 4'd10);   // grant
      send_request(REQ_RELEASE, 4'd10);   // freed with an empty queue

      // random episodes
      deep_done = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (!deep_done && sent >= 150) begin
            // deep recursion: one thread climbs to saturation and back down
            deep_done = 1;
            drain_lock();
            do tid = TID_WIDTH'($urandom_range(15)); while (waiting_map[tid]);
            reps = 256 + $urandom_range(6);
            repeat (reps) send_request(REQ_ACQUIRE, tid);
            repeat (reps + 1) send_request(REQ_RELEASE, tid);
         end else if (roll < 55) begin
            // contention among a few threads, releases mostly by the holder
            pool_size = $urandom_range(2, 5);
            for (int i = 0; i < pool_size; i++) pool[i] = TID_WIDTH'($urandom_range(15));
            repeat ($urandom_range(8, 30)) begin
               tid = pool[$urandom_range(pool_size - 1)];
               if ($urandom_range(99) < 50) begin
                  send_request(REQ_ACQUIRE, tid);
               end else if (lock_held && $urandom_range(99) < 70) begin
                  send_request(REQ_RELEASE, lock_owner);
               end else begin
                  send_request(REQ_RELEASE, tid);
               end
            end
         end else if (roll < 80) begin
            // crowd the wait queue, hand the lock over, then a few acquires
            repeat ($urandom_range(0, 20)) begin
               send_request(REQ_ACQUIRE, TID_WIDTH'($urandom_range(15)));
            end
            drain_lock();
            repeat ($urandom_range(1, 3)) begin
               send_request(REQ_ACQUIRE, TID_WIDTH'($urandom_range(15)));
            end
         end else begin
            // noise
            repeat ($urandom_range(1, 10)) begin
               send_request(req_kind_type'($urandom_range(1)),
                            TID_WIDTH'($urandom_range(15)));
            end
         end
      end
      start <= 1'b0;

      // let the last results come back
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("run covered %0d request transfers and %0d checked results", sent, checked);
      $display("status codes seen, one bit per code: %b", status_mask);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
